// ===== hw/rtl/tps_pkg.sv =====
`timescale 1ns / 1ps

package tps_pkg;

	// widths of the range and position fields
	localparam int DIST_BITS = 16;
	localparam int OUT_BITS  = 32;

	// anchor registers
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int DV_W      = CFG_W + 1;

	localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_B_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_C_X = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_C_Y = 2'd2;

	localparam logic [CFG_W-1:0] ANCHOR_B_X_RST = 16'd2985;
	localparam logic [CFG_W-1:0] ANCHOR_C_X_RST = 16'd463;
	localparam logic [CFG_W-1:0] ANCHOR_C_Y_RST = 16'd5045;

	// datapath widths
	localparam int SQ_W   = 2 * DIST_BITS;
	localparam int NX_W   = ((SQ_W > 32) ? SQ_W : 32) + 2;
	localparam int NXM_W  = NX_W - 1;
	localparam int NY_W   = ((SQ_W > 33) ? SQ_W : 33) + 2;
	localparam int PR_W   = OUT_BITS + DV_W;
	localparam int NUM_W  = ((NY_W > PR_W) ? NY_W : PR_W) + 1;
	localparam int NUMM_W = NUM_W - 1;

	typedef struct packed {
		logic [DIST_BITS-1:0] dist_a;
		logic [DIST_BITS-1:0] dist_b;
		logic [DIST_BITS-1:0] dist_c;
	} dist_req_t;

	typedef struct packed {
		logic signed [OUT_BITS-1:0] pos_x;
		logic signed [OUT_BITS-1:0] pos_y;
		logic                       status;
	} pos_req_t;

endpackage

// ===== hw/rtl/tps_div_pipe.sv =====
`timescale 1ns / 1ps

// restoring divider, one quotient bit per stage, side data travels along
module tps_div_pipe import tps_pkg::*; #(
	parameter int N    = NXM_W,
	parameter int SB_W = NY_W + 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [N-1:0]    num,
	input  logic [DV_W-1:0] div,
	input  logic [SB_W-1:0] side_in,
	output logic            out_valid,
	output logic [N-1:0]    quo,
	output logic [SB_W-1:0] side_out
);

	logic            vld_s  [N];
	logic [DV_W-1:0] rem_s  [N];
	logic [N-1:0]    nq_s   [N];
	logic [SB_W-1:0] side_s [N];

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic            vld_in;
		logic [DV_W-1:0] rem_in;
		logic [N-1:0]    nq_in;
		logic [SB_W-1:0] side_k;
		logic [DV_W:0]   trial;
		logic [DV_W:0]   diff;
		logic            take;

		if (k == 0) begin : g_first
			assign vld_in = in_valid;
			assign rem_in = '0;
			assign nq_in  = num;
			assign side_k = side_in;
		end else begin : g_next
			assign vld_in = vld_s[k-1];
			assign rem_in = rem_s[k-1];
			assign nq_in  = nq_s[k-1];
			assign side_k = side_s[k-1];
		end

		// shift in the next numerator bit and try the subtract
		assign trial = {rem_in, nq_in[N-1]};
		assign diff  = trial - {1'b0, div};
		assign take  = (trial >= {1'b0, div});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= take ? diff[DV_W-1:0] : trial[DV_W-1:0];
				nq_s[k]   <= {nq_in[N-2:0], take};
				side_s[k] <= side_k;
			end
		end
	end

	assign out_valid = vld_s[N-1];
	assign quo       = nq_s[N-1];
	assign side_out  = side_s[N-1];

endmodule

// ===== hw/rtl/trilateration_position_solver.sv =====
`timescale 1ns / 1ps

// 2d position from three ranges: anchor a at the origin, anchor b at (anchor_b_x, 0),
// anchor c at (anchor_c_x, anchor_c_y). each request on the dist channel carries
// dist_a/dist_b/dist_c and gives exactly one request on the pos channel, in order.
// x = trunc((a^2 - b^2 + bx^2) / 2bx), y = trunc((a^2 - c^2 + cx^2 + cy^2 - 2cx*x) / 2cy),
// both truncated toward zero and saturated; a zero range gives status 1 and a zero position.
// a zero divisor anchor gives 0 for that coordinate.
// throughput: one request per cycle; a request is taken whenever dist_stall is low.
// between accept and pos_valid lie the squares and numerator stages and the two
// bit-per-stage dividers (x quotient, then y quotient).
// anchor registers are written over the cfg channel (cfg_ready is always high) and
// must only change while no request is in flight.
// reset clears every valid bit and loads the default anchor positions.
// a stalled output request holds in the output register; one more result drops into
// a skid register, and only while that one waits is dist_stall raised and the
// whole pipeline held in place.
module trilateration_position_solver import tps_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 dist_valid,
	output logic                 dist_stall,
	input  dist_req_t            dist_req,
	output logic                 pos_valid,
	input  logic                 pos_stall,
	output pos_req_t             pos_req,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	// side data carried through the two dividers
	typedef struct packed {
		logic signed [NY_W-1:0] ny;
		logic                   neg;
		logic                   zero;
	} xsb_t;

	typedef struct packed {
		logic signed [OUT_BITS-1:0] xs;
		logic                       neg;
		logic                       zero;
	} ysb_t;

	localparam logic [NUMM_W-1:0] MAG_HI = {{(NUMM_W-OUT_BITS+1){1'b0}}, {(OUT_BITS-1){1'b1}}};
	localparam logic [NUMM_W-1:0] MAG_LO = MAG_HI + 1'b1;

	// signed magnitude to saturated output width
	function automatic logic signed [OUT_BITS-1:0] sat_q(input logic neg,
			input logic [NUMM_W-1:0] mag);
		logic [NUMM_W-1:0] val;
		val = neg ? (~mag + 1'b1) : mag;
		if (!neg && (mag > MAG_HI)) begin
			return {1'b0, {(OUT_BITS-1){1'b1}}};
		end else if (neg && (mag > MAG_LO)) begin
			return {1'b1, {(OUT_BITS-1){1'b0}}};
		end else begin
			return val[OUT_BITS-1:0];
		end
	endfunction

	// anchor registers
	logic [CFG_W-1:0]        anchor_b_x_q;
	logic signed [CFG_W-1:0] anchor_c_x_q;
	logic [CFG_W-1:0]        anchor_c_y_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			anchor_b_x_q <= ANCHOR_B_X_RST;
			anchor_c_x_q <= ANCHOR_C_X_RST;
			anchor_c_y_q <= ANCHOR_C_Y_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ANCHOR_B_X: anchor_b_x_q <= cfg_wdata;
				REG_ANCHOR_C_X: anchor_c_x_q <= cfg_wdata;
				REG_ANCHOR_C_Y: anchor_c_y_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// pipeline advance: only held while the skid register is full
	logic en;
	logic skid_valid_q;
	logic out_valid_q;
	pos_req_t out_q;
	pos_req_t skid_q;

	assign en         = !skid_valid_q;
	assign dist_stall = skid_valid_q;

	// s1: squares
	logic                       v_s1;
	logic                       zero_s1;
	logic [SQ_W-1:0]            sq_a_s1;
	logic [SQ_W-1:0]            sq_b_s1;
	logic [SQ_W-1:0]            sq_c_s1;
	logic [2*CFG_W-1:0]         bx_sq_s1;
	logic [2*CFG_W-1:0]         cx_sq_s1;
	logic [2*CFG_W-1:0]         cy_sq_s1;
	logic signed [2*CFG_W-1:0]  cx_sq_w;

	assign cx_sq_w = anchor_c_x_q * anchor_c_x_q;

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s1  <= (dist_req.dist_a == '0) || (dist_req.dist_b == '0) ||
				(dist_req.dist_c == '0);
			sq_a_s1  <= SQ_W'(dist_req.dist_a) * SQ_W'(dist_req.dist_a);
			sq_b_s1  <= SQ_W'(dist_req.dist_b) * SQ_W'(dist_req.dist_b);
			sq_c_s1  <= SQ_W'(dist_req.dist_c) * SQ_W'(dist_req.dist_c);
			bx_sq_s1 <= (2*CFG_W)'(anchor_b_x_q) * (2*CFG_W)'(anchor_b_x_q);
			cx_sq_s1 <= cx_sq_w;
			cy_sq_s1 <= (2*CFG_W)'(anchor_c_y_q) * (2*CFG_W)'(anchor_c_y_q);
		end
	end

	// s2: both numerators before the x term
	logic                   v_s2;
	logic                   zero_s2;
	logic signed [NX_W-1:0] nx_s2;
	logic signed [NY_W-1:0] ny_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s2 <= zero_s1;
			nx_s2   <= $signed(NX_W'(sq_a_s1)) - $signed(NX_W'(sq_b_s1)) +
				$signed(NX_W'(bx_sq_s1));
			ny_s2   <= $signed(NY_W'(sq_a_s1)) - $signed(NY_W'(sq_c_s1)) +
				$signed(NY_W'(cx_sq_s1)) + $signed(NY_W'(cy_sq_s1));
		end
	end

	// s3: sign and magnitude of the x numerator
	logic                   v_s3;
	xsb_t                   xsb_s3;
	logic [NXM_W-1:0]       nx_mag_s3;
	logic signed [NX_W-1:0] nx_abs;

	assign nx_abs = nx_s2[NX_W-1] ? -nx_s2 : nx_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			xsb_s3.ny   <= ny_s2;
			xsb_s3.neg  <= nx_s2[NX_W-1];
			xsb_s3.zero <= zero_s2;
			nx_mag_s3   <= nx_abs[NXM_W-1:0];
		end
	end

	// x divider by 2*bx
	logic             xq_valid;
	logic [NXM_W-1:0] xq;
	xsb_t             xsb_q;

	tps_div_pipe #(
		.N    (NXM_W),
		.SB_W ($bits(xsb_t))
	) u_div_x (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.num       (nx_mag_s3),
		.div       ({anchor_b_x_q, 1'b0}),
		.side_in   (xsb_s3),
		.out_valid (xq_valid),
		.quo       (xq),
		.side_out  (xsb_q)
	);

	// s4: saturated x, zero when anchor b sits on the origin
	logic                       v_s4;
	logic                       zero_s4;
	logic signed [NY_W-1:0]     ny_s4;
	logic signed [OUT_BITS-1:0] xs_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s4 <= xsb_q.zero;
			ny_s4   <= xsb_q.ny;
			xs_s4   <= (anchor_b_x_q == '0) ? '0 : sat_q(xsb_q.neg, NUMM_W'(xq));
		end
	end

	// s5: 2*cx*x
	logic                       v_s5;
	logic                       zero_s5;
	logic signed [NY_W-1:0]     ny_s5;
	logic signed [OUT_BITS-1:0] xs_s5;
	logic signed [PR_W-1:0]     prod_s5;
	logic signed [DV_W-1:0]     p2_w;

	assign p2_w = {anchor_c_x_q, 1'b0};

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s5 <= zero_s4;
			ny_s5   <= ny_s4;
			xs_s5   <= xs_s4;
			prod_s5 <= p2_w * xs_s4;
		end
	end

	// s6: full y numerator
	logic                       v_s6;
	logic                       zero_s6;
	logic signed [OUT_BITS-1:0] xs_s6;
	logic signed [NUM_W-1:0]    num_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s6 <= zero_s5;
			xs_s6   <= xs_s5;
			num_s6  <= NUM_W'(ny_s5) - NUM_W'(prod_s5);
		end
	end

	// s7: sign and magnitude of the y numerator
	logic                    v_s7;
	ysb_t                    ysb_s7;
	logic [NUMM_W-1:0]       num_mag_s7;
	logic signed [NUM_W-1:0] num_abs;

	assign num_abs = num_s6[NUM_W-1] ? -num_s6 : num_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			ysb_s7.xs   <= xs_s6;
			ysb_s7.neg  <= num_s6[NUM_W-1];
			ysb_s7.zero <= zero_s6;
			num_mag_s7  <= num_abs[NUMM_W-1:0];
		end
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= dist_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= xq_valid;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// y divider by 2*cy
	logic              yq_valid;
	logic [NUMM_W-1:0] yq;
	ysb_t              ysb_q;

	tps_div_pipe #(
		.N    (NUMM_W),
		.SB_W ($bits(ysb_t))
	) u_div_y (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s7),
		.num       (num_mag_s7),
		.div       ({anchor_c_y_q, 1'b0}),
		.side_in   (ysb_s7),
		.out_valid (yq_valid),
		.quo       (yq),
		.side_out  (ysb_q)
	);

	// final result: saturate y, apply the zero-range and zero-divisor cases
	pos_req_t res_w;

	always_comb begin
		res_w.pos_x  = ysb_q.xs;
		res_w.pos_y  = (anchor_c_y_q == '0) ? '0 : sat_q(ysb_q.neg, yq);
		res_w.status = 1'b0;
		if (ysb_q.zero) begin
			res_w.pos_x  = '0;
			res_w.pos_y  = '0;
			res_w.status = 1'b1;
		end
	end

	// output register and skid register
	logic take;

	assign take = out_valid_q && !pos_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (yq_valid) begin
			if (!out_valid_q || take) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (yq_valid) begin
			if (!out_valid_q || take) begin
				out_q <= res_w;
			end else begin
				skid_q <= res_w;
			end
		end
	end

	assign pos_valid = out_valid_q;
	assign pos_req   = out_q;

	// a filled skid register always sits behind a waiting output request
	assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register full with empty output register");

	// the skid register only drains when the output request is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && !take) |=> skid_valid_q)
		else $error("skid register dropped a result");

	// a zero-range result carries a zero position
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.status) |-> ((out_q.pos_x == '0) && (out_q.pos_y == '0)))
		else $error("zero-range result with nonzero position");

	// while held, the last divider stage keeps its valid bit
	assert property (@(posedge clk) disable iff (!arst_n)
		(!en && yq_valid) |=> yq_valid)
		else $error("held pipeline lost a result");

endmodule
